// File: hw/rtl/distance_vector_route_table_unit_macros.svh
// assertion macros for the route table unit
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_UNIT_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_UNIT_MACROS_SVH
`define DVRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DVRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/dvrt_pkg.sv
// package for the route table unit: widths, codes, states
package dvrt_pkg;
	localparam int ROUTE_DEPTH_DEF = 32;
	localparam int PORT_COUNT_DEF = 16;
	localparam int IdW = 16;
	localparam int CostW = 16;
	localparam int PortW = 4;
	localparam int RttlW = 6;
	localparam int PttlW = 4;
	localparam logic [PttlW-1:0] PORT_TTL_FULL = 4'd15;
	localparam logic [RttlW-1:0] ROUTE_TTL_FULL = 6'd45;

	typedef enum logic [1:0] {
		REQ_PONG = 2'd0, REQ_DV = 2'd1, REQ_TICK = 2'd2, REQ_ADV = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_DONE = 3'd0, ST_SELF = 3'd1, ST_FULL = 3'd2, ST_UNKNOWN = 3'd3, ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_OWN = 2'd0, CFG_PORTS = 2'd1, CFG_INF = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_PSRCH, S_PWAIT, S_MRD, S_MCMP, S_MWR,
		S_TRD, S_TCMP, S_PAGE, S_ARD, S_ACMP, S_OUT
	} state_t;

	localparam int EntW = IdW + IdW + PortW + CostW + RttlW;

	typedef struct packed {
		logic [IdW-1:0]   dest;
		logic [IdW-1:0]   via;
		logic [PortW-1:0] port;
		logic [CostW-1:0] cost;
		logic [RttlW-1:0] ttl;
	} route_t;
endpackage

// File: hw/rtl/dvrt_ram.sv
// generic ram with one write port and one registered read port
module dvrt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/distance_vector_route_table_unit.sv
// distance-vector route table unit: top level
// routes live in one ram, read one entry at a time; port table in registers
// pong: route walk (read, compare), then write; dv: port search first, then the same walk
// tick: route walk dropping expired routes, then port ageing; advertise: one result per route
// advertise waits for each result to be taken; next item taken the cycle after the last result
// arst_n resets control state, config, route count and port table at once
`include "distance_vector_route_table_unit_macros.svh"
module distance_vector_route_table_unit
	import dvrt_pkg::*;
#(
	parameter int ROUTE_DEPTH = ROUTE_DEPTH_DEF,
	parameter int PORT_COUNT = PORT_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [PortW-1:0] port_index,
	input  logic [IdW-1:0]   peer_id,
	input  logic [IdW-1:0]   dest_id,
	input  logic [CostW-1:0] cost_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [IdW-1:0]   adv_dest,
	output logic [CostW-1:0] adv_cost,
	output logic             last,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	localparam int RaW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
	localparam int CntW = $clog2(ROUTE_DEPTH + 1);
	localparam int PiW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int PcW = $clog2(PORT_COUNT + 1);

	state_t state_q, state_d;
	logic [IdW-1:0] own_q;
	logic [4:0] ports_q;
	logic [CostW-1:0] inf_q;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] idx_q, kept_q;
	logic [PcW-1:0] pidx_q;
	logic [1:0] req_q;
	logic [IdW-1:0] nb_q, mdest_q, mnext_q;
	logic [CostW-1:0] cin_q, mcost_q;
	logic [PortW-1:0] mport_q;
	logic [CntW-1:0] hit_q;
	logic hit_found_q;

	logic [IdW-1:0] pn_q [PORT_COUNT];
	logic [CostW-1:0] pc_q [PORT_COUNT];
	logic [PttlW-1:0] pt_q [PORT_COUNT];
	logic pa_q [PORT_COUNT];

	logic ov_q;
	logic [2:0] st_q;
	logic [IdW-1:0] ad_q;
	logic [CostW-1:0] ac_q;
	logic last_q;

	logic we;
	logic [RaW-1:0] waddr, raddr;
	route_t wdata, rdata;
	logic [EntW-1:0] rraw;
	logic [CntW-1:0] idx_prev;

	dvrt_ram #(.Width(EntW), .Depth(ROUTE_DEPTH)) u_route_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rraw)
	);
	assign rdata = route_t'(rraw);
	assign idx_prev = idx_q - CntW'(1);

	logic [PcW-1:0] nact;
	always_comb begin
		if (32'(ports_q) < 32'(PORT_COUNT))
			nact = PcW'(ports_q);
		else
			nact = PcW'(PORT_COUNT);
	end

	logic [CostW-1:0] cin_clip;
	assign cin_clip = (cost_in > inf_q) ? inf_q : cost_in;
	logic [CostW:0] dvsum;
	assign dvsum = {1'b0, pc_q[pidx_q[PiW-1:0]]} + {1'b0, cin_q};

	assign cfg_ready = (state_q == S_IDLE) && !ov_q;
	assign in_stall = !((state_q == S_IDLE) && !ov_q);
	logic acc;
	assign acc = in_valid && !in_stall;
	logic take;
	assign take = ov_q && !out_stall;

	logic emit;
	logic [2:0] emit_st;
	logic [CostW-1:0] emit_cost;
	logic emit_last, emit_adv;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = idx_q[RaW-1:0];
		wdata = rdata;
		raddr = idx_q[RaW-1:0];
		emit = 1'b0;
		emit_st = ST_DONE;
		emit_cost = '0;
		emit_last = 1'b1;
		emit_adv = 1'b0;
		unique case (state_q)
			S_IDLE: if (acc) begin
				unique case (req_t'(req_type))
					REQ_PONG: state_d = S_MRD;
					REQ_DV: state_d = S_PSRCH;
					REQ_TICK: state_d = S_TRD;
					REQ_ADV: state_d = S_ARD;
					default: state_d = S_IDLE;
				endcase
			end
			S_PSRCH: begin
				if (pidx_q >= nact) begin
					emit = 1'b1; emit_st = ST_UNKNOWN; state_d = S_OUT;
				end else if (pn_q[pidx_q[PiW-1:0]] == nb_q) state_d = S_PWAIT;
			end
			S_PWAIT: state_d = S_MRD;
			S_MRD: begin
				if (mdest_q == own_q) begin
					emit = 1'b1; emit_st = ST_SELF; state_d = S_OUT;
				end else if (idx_q >= cnt_q) state_d = S_MWR;
				else state_d = S_MCMP;
			end
			S_MCMP: begin
				// keep the compared entry on the read port for the write decision
				raddr = idx_prev[RaW-1:0];
				state_d = (rdata.dest == mdest_q) ? S_MWR : S_MRD;
			end
			S_MWR: begin
				emit = 1'b1;
				wdata = '{dest: mdest_q, via: mnext_q, port: mport_q,
					cost: mcost_q, ttl: ROUTE_TTL_FULL};
				if (hit_found_q) begin
					waddr = hit_q[RaW-1:0];
					we = (rdata.cost >= mcost_q);
				end else if (cnt_q >= CntW'(ROUTE_DEPTH)) emit_st = ST_FULL;
				else begin
					waddr = cnt_q[RaW-1:0];
					we = 1'b1;
				end
				state_d = S_OUT;
			end
			S_TRD: state_d = (idx_q >= cnt_q) ? S_PAGE : S_TCMP;
			S_TCMP: begin
				waddr = kept_q[RaW-1:0];
				wdata = rdata;
				wdata.ttl = rdata.ttl - 6'd1;
				we = (rdata.ttl > 6'd1);
				state_d = S_TRD;
			end
			S_PAGE: if (pidx_q >= nact) begin
				emit = 1'b1; state_d = S_OUT;
			end
			S_ARD: begin
				if (cnt_q == '0) begin
					emit = 1'b1; emit_st = ST_EMPTY; state_d = S_OUT;
				end else state_d = S_ACMP;
			end
			S_ACMP: begin
				emit = 1'b1; emit_adv = 1'b1;
				emit_cost = (rdata.via == nb_q) ? inf_q : rdata.cost;
				emit_last = (idx_q + CntW'(1) == cnt_q);
				state_d = S_OUT;
			end
			S_OUT: if (take) begin
				if (req_q == REQ_ADV && !last_q) state_d = S_ARD;
				else state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0; ports_q <= '0; inf_q <= '1;
			cnt_q <= '0; idx_q <= '0; kept_q <= '0; pidx_q <= '0;
			req_q <= REQ_PONG; hit_found_q <= 1'b0; hit_q <= '0;
			ov_q <= 1'b0;
			for (int p = 0; p < PORT_COUNT; p++) begin
				pn_q[p] <= '0; pc_q[p] <= '1; pt_q[p] <= '0; pa_q[p] <= 1'b0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_OWN: own_q <= cfg_data;
					CFG_PORTS: ports_q <= cfg_data[4:0];
					CFG_INF: inf_q <= cfg_data;
					default: ;
				endcase
			end
			if (take) ov_q <= 1'b0;
			if (emit) begin
				ov_q <= 1'b1;
				st_q <= emit_st;
				ad_q <= emit_adv ? rdata.dest : '0;
				ac_q <= emit_cost;
				last_q <= emit_last;
			end
			unique case (state_q)
				S_IDLE: if (acc) begin
					req_q <= req_type; nb_q <= peer_id;
					cin_q <= cost_in; idx_q <= '0; kept_q <= '0; pidx_q <= '0;
					hit_found_q <= 1'b0;
					mdest_q <= (req_type == REQ_PONG) ? peer_id : dest_id;
					mnext_q <= peer_id;
					mport_q <= port_index;
					mcost_q <= cin_clip;
					if (req_type == REQ_PONG && 32'(port_index) < 32'(nact)) begin
						pn_q[PiW'(port_index)] <= peer_id;
						pc_q[PiW'(port_index)] <= cin_clip;
						pt_q[PiW'(port_index)] <= PORT_TTL_FULL;
						pa_q[PiW'(port_index)] <= 1'b1;
					end
				end
				S_PSRCH: if (pidx_q < nact) begin
					if (pn_q[pidx_q[PiW-1:0]] == nb_q) begin
						mport_q <= PortW'(pidx_q);
						mcost_q <= (dvsum > {1'b0, inf_q}) ? inf_q : dvsum[CostW-1:0];
					end else pidx_q <= pidx_q + PcW'(1);
				end
				S_MRD: if (idx_q < cnt_q) idx_q <= idx_q + CntW'(1);
				S_MCMP: if (rdata.dest == mdest_q) begin
					hit_found_q <= 1'b1;
					hit_q <= idx_prev;
				end
				S_MWR: if (!hit_found_q && cnt_q < CntW'(ROUTE_DEPTH))
					cnt_q <= cnt_q + CntW'(1);
				S_TRD: if (idx_q < cnt_q) idx_q <= idx_q + CntW'(1);
				else cnt_q <= kept_q;
				S_TCMP: if (rdata.ttl > 6'd1) kept_q <= kept_q + CntW'(1);
				S_PAGE: if (pidx_q < nact) begin
					if (pt_q[pidx_q[PiW-1:0]] <= PttlW'(1)) begin
						pa_q[pidx_q[PiW-1:0]] <= 1'b0;
						pt_q[pidx_q[PiW-1:0]] <= '0;
					end else pt_q[pidx_q[PiW-1:0]] <= pt_q[pidx_q[PiW-1:0]] - PttlW'(1);
					pidx_q <= pidx_q + PcW'(1);
				end
				S_ACMP: idx_q <= idx_q + CntW'(1);
				default: ;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign status = st_q;
	assign adv_dest = ad_q;
	assign adv_cost = ac_q;
	assign last = last_q;

	`DVRT_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CntW'(ROUTE_DEPTH))
	`DVRT_ASSERT_IMPL(a_busy_stall, clk, arst_n, state_q != S_IDLE, in_stall)
	`DVRT_ASSERT_NEXT(a_hold_out, clk, arst_n, ov_q && out_stall, ov_q && $stable(st_q))
	`DVRT_ASSERT_IMPL(a_kept_le_idx, clk, arst_n, 1'b1, kept_q <= idx_q)
endmodule

// File: tb/sv/dvrt_checker.sv
// route table unit checker: watches the channels, predicts results and compares them
`timescale 1ns / 100ps
module dvrt_checker
	import dvrt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [PortW-1:0] port_index,
	input  logic [IdW-1:0]   peer_id,
	input  logic [IdW-1:0]   dest_id,
	input  logic [CostW-1:0] cost_in,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [2:0]       status,
	input  logic [IdW-1:0]   adv_dest,
	input  logic [CostW-1:0] adv_cost,
	input  logic             last,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output int               fails,
	output int               pending,
	output int               checked
);
	localparam int NRT = ROUTE_DEPTH_DEF;
	localparam int NPT = PORT_COUNT_DEF;

	typedef struct packed {
		status_t          st;
		logic [IdW-1:0]   dest;
		logic [CostW-1:0] cost;
		logic             fin;
	} reply_t;

	reply_t reply_q[$];

	logic [IdW-1:0]   own_id;
	logic [4:0]       ports_on;
	logic [CostW-1:0] inf_cost;

	route_t           rt[NRT];
	int               rt_count;
	logic [IdW-1:0]   pt_nb[NPT];
	logic [CostW-1:0] pt_cost[NPT];
	logic [PttlW-1:0] pt_ttl[NPT];
	logic             pt_alive[NPT];

	function automatic logic [CostW-1:0] clip(input logic [IdW:0] c);
		return (c > inf_cost) ? inf_cost : c[CostW-1:0];
	endfunction

	function automatic int live_ports();
		return (ports_on < NPT) ? int'(ports_on) : NPT;
	endfunction

	function automatic status_t fold_route(input logic [IdW-1:0] d, input logic [IdW-1:0] nh,
			input logic [PortW-1:0] p, input logic [CostW-1:0] c);
		if (d == own_id)
			return ST_SELF;
		for (int i = 0; i < rt_count; i++) begin
			if (rt[i].dest == d) begin
				if (rt[i].cost >= c) begin
					rt[i].cost = c;
					rt[i].via = nh;
					rt[i].port = p;
					rt[i].ttl = ROUTE_TTL_FULL;
				end
				return ST_DONE;
			end
		end
		if (rt_count >= NRT)
			return ST_FULL;
		rt[rt_count] = '{dest: d, via: nh, port: p, cost: c, ttl: ROUTE_TTL_FULL};
		rt_count++;
		return ST_DONE;
	endfunction

	task automatic predict_item();
		status_t st;
		int kept;
		int hit;
		logic [CostW-1:0] c;
		reply_t r;
		st = ST_DONE;
		case (req_t'(req_type))
			REQ_ADV: begin
				if (rt_count == 0) begin
					r = '{ST_EMPTY, '0, '0, 1'b1};
					reply_q.insert(reply_q.size(), r);
				end else begin
					for (int i = 0; i < rt_count; i++) begin
						r = '{ST_DONE, rt[i].dest,
							(rt[i].via == peer_id) ? inf_cost : rt[i].cost,
							i == rt_count - 1};
						reply_q.insert(reply_q.size(), r);
					end
				end
				return;
			end
			REQ_PONG: begin
				c = clip({1'b0, cost_in});
				if (port_index < live_ports()) begin
					pt_nb[port_index] = peer_id;
					pt_cost[port_index] = c;
					pt_ttl[port_index] = PORT_TTL_FULL;
					pt_alive[port_index] = 1'b1;
				end
				st = fold_route(peer_id, peer_id, port_index, c);
			end
			REQ_DV: begin
				hit = -1;
				for (int i = 0; i < live_ports(); i++)
					if (hit < 0 && pt_nb[i] == peer_id)
						hit = i;
				if (hit < 0)
					st = ST_UNKNOWN;
				else
					st = fold_route(dest_id, peer_id, hit[PortW-1:0],
						clip({1'b0, pt_cost[hit]} + {1'b0, cost_in}));
			end
			default: begin
				kept = 0;
				for (int i = 0; i < rt_count; i++) begin
					if (rt[i].ttl > 1) begin
						rt[kept] = rt[i];
						rt[kept].ttl = rt[i].ttl - RttlW'(1);
						kept++;
					end
				end
				rt_count = kept;
				for (int i = 0; i < live_ports(); i++) begin
					if (pt_ttl[i] > 0)
						pt_ttl[i] = pt_ttl[i] - PttlW'(1);
					if (pt_ttl[i] == 0)
						pt_alive[i] = 1'b0;
				end
			end
		endcase
		r = '{st, '0, '0, 1'b1};
		reply_q.insert(reply_q.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			own_id <= '0;
			ports_on <= '0;
			inf_cost <= '1;
			rt_count = 0;
			for (int i = 0; i < NPT; i++) begin
				pt_nb[i] = '0;
				pt_cost[i] = '1;
				pt_ttl[i] = '0;
				pt_alive[i] = 1'b0;
			end
			reply_q.delete();
			fails <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reply_q.size() == 0) begin
					if (fails < 10)
						$display("unexpected transfer: status %0d dest %0d cost %0d last %0b",
							status, adv_dest, adv_cost, last);
					fails <= fails + 1;
				end else begin
					want = reply_q.pop_front();
					checked <= checked + 1;
					if (status !== want.st || adv_dest !== want.dest ||
							adv_cost !== want.cost || last !== want.fin) begin
						if (fails < 10)
							$display("mismatch: exp st %0d dest %0d cost %0d last %0b, got %0d %0d %0d %0b",
								want.st, want.dest, want.cost, want.fin,
								status, adv_dest, adv_cost, last);
						fails <= fails + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_OWN:   own_id <= cfg_data;
					CFG_PORTS: ports_on <= cfg_data[4:0];
					CFG_INF:   inf_cost <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_item();
			pending <= reply_q.size();
		end
	end
endmodule

// File: tb/sv/tb.sv
// testbench top for the route table unit: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb
	import dvrt_pkg::*;
();

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       req_type;
	logic [PortW-1:0] port_index;
	logic [IdW-1:0]   peer_id;
	logic [IdW-1:0]   dest_id;
	logic [CostW-1:0] cost_in;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [2:0]       status;
	logic [IdW-1:0]   adv_dest;
	logic [CostW-1:0] adv_cost;
	logic             last;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [15:0]      cfg_data;

	int fails;
	int pending;
	int checked;
	int idle_pct;
	int stall_pct;
	int hold_left = 0;
	bit hold_start;
	bit hold_done = 1'b0;
	int cycles = 0;
	int sent;
	logic [IdW-1:0] own_now;
	logic [IdW-1:0] nb_pool[$];

	distance_vector_route_table_unit uut (.*);

	dvrt_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stall, plus one long hold-off
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_start && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= 300;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_item(input req_t r, input logic [PortW-1:0] p, input logic [IdW-1:0] nb,
			input logic [IdW-1:0] d, input logic [CostW-1:0] c);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r;
		port_index <= p;
		peer_id <= nb;
		dest_id <= d;
		cost_in <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// sender pauses until every result has come, then lets the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || out_valid)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] own, input logic [15:0] ports,
			input logic [15:0] inf);
		drain();
		write_reg(CFG_OWN, own);
		write_reg(CFG_PORTS, ports);
		write_reg(CFG_INF, inf);
		own_now = own;
	endtask

	task automatic random_item();
		int sel;
		logic [IdW-1:0] nb;
		logic [IdW-1:0] d;
		logic [CostW-1:0] c;
		logic [PortW-1:0] p;
		sel = $urandom_range(99);
		p = 4'($urandom_range(15));
		nb = (nb_pool.size() != 0 && $urandom_range(9) < 7) ?
			nb_pool[$urandom_range(nb_pool.size() - 1)] : 16'($urandom_range(65535));
		case ($urandom_range(9))
			0: d = own_now;
			1, 2, 3: d = 16'($urandom_range(40));
			4: d = nb;
			default: d = 16'($urandom_range(65535));
		endcase
		c = ($urandom_range(9) < 6) ? 16'($urandom_range(200)) : 16'($urandom_range(65535));
		if (sel < 25) begin
			if (nb_pool.size() < 8)
				nb_pool.insert(nb_pool.size(), nb);
			send_item(REQ_PONG, p, nb, d, c);
		end else if (sel < 70) begin
			send_item(REQ_DV, p, nb, d, c);
		end else if (sel < 82) begin
			send_item(REQ_TICK, p, nb, d, c);
		end else begin
			send_item(REQ_ADV, p, nb, d, c);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PONG;
		port_index = '0;
		peer_id = '0;
		dest_id = '0;
		cost_in = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_OWN;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_start = 1'b0;
		sent = 0;
		own_now = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		set_regs(16'd100, 16'd4, 16'hffff);
		send_item(REQ_ADV, 4'd0, 16'd0, 16'd0, 16'd0);
		send_item(REQ_PONG, 4'd0, 16'd1, 16'd0, 16'd10);
		send_item(REQ_PONG, 4'd3, 16'd2, 16'd0, 16'hffff);
		send_item(REQ_PONG, 4'd5, 16'd7, 16'd0, 16'd20);
		send_item(REQ_PONG, 4'd1, 16'd100, 16'd0, 16'd5);
		send_item(REQ_DV, 4'd0, 16'd1, 16'd50, 16'd5);
		send_item(REQ_DV, 4'd0, 16'd9, 16'd51, 16'd1);
		send_item(REQ_DV, 4'd0, 16'd9, 16'd100, 16'd1);
		send_item(REQ_DV, 4'd0, 16'd1, 16'd100, 16'd1);
		send_item(REQ_DV, 4'd0, 16'd2, 16'd52, 16'hffff);
		send_item(REQ_DV, 4'd0, 16'd1, 16'd50, 16'd100);
		send_item(REQ_DV, 4'd0, 16'd2, 16'd50, 16'd0);
		send_item(REQ_DV, 4'd0, 16'd1, 16'd50, 16'd5);
		send_item(REQ_ADV, 4'd0, 16'd1, 16'd0, 16'd0);
		send_item(REQ_ADV, 4'd0, 16'hffff, 16'hffff, 16'hffff);
		send_item(REQ_TICK, 4'hf, 16'h0, 16'h0, 16'h0);
		send_item(REQ_PONG, 4'hf, 16'hffff, 16'hffff, 16'd0);
		send_item(REQ_DV, 4'd0, 16'd0, 16'hffff, 16'd0);
		set_regs(16'd100, 16'd4, 16'd200);
		send_item(REQ_PONG, 4'd2, 16'd3, 16'd0, 16'd500);
		send_item(REQ_DV, 4'd0, 16'd3, 16'd60, 16'hffff);
		send_item(REQ_ADV, 4'd0, 16'd3, 16'd0, 16'd0);

		// random phases over several settings and idling mixes
		set_regs(16'hffff, 16'd16, 16'hffff);
		for (int i = 0; i < 8; i++)
			random_item();
		set_regs(16'd0, 16'd7, 16'd1000);
		idle_pct = 57;
		for (int i = 0; i < 8; i++)
			random_item();
		set_regs(16'd5, 16'd0, 16'd1);
		idle_pct = 0;
		stall_pct = 57;
		for (int i = 0; i < 8; i++)
			random_item();
		set_regs(16'd300, 16'd16, 16'd500);
		idle_pct = 21;
		stall_pct = 21;
		hold_start = 1'b1;
		for (int i = 0; i < 10; i++)
			random_item();

		// fill the route table, then age everything out
		set_regs(16'h1234, 16'd16, 16'hffff);
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < 4; i++)
			send_item(REQ_PONG, i[3:0], 16'd2000 + i[15:0], 16'd0, 16'd3 + i[15:0]);
		for (int i = 0; i < 28; i++)
			send_item(REQ_DV, 4'd0, 16'(2000 + i % 4), 16'd1000 + i[15:0], i[15:0]);
		send_item(REQ_ADV, 4'd0, 16'd2001, 16'd0, 16'd0);
		for (int i = 0; i < 46; i++)
			send_item(REQ_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
		send_item(REQ_ADV, 4'd0, 16'd2000, 16'd0, 16'd0);

		drain();
		$display("covered %0d items and %0d results over seven register settings,", sent, checked);
		$display("with sender gaps, receiver stalls, a long hold-off and a full table");
		if (fails == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// File: distance_vector_route_table_unit.f
+incdir+hw/rtl
hw/rtl/dvrt_pkg.sv
hw/rtl/dvrt_ram.sv
hw/rtl/distance_vector_route_table_unit.sv
tb/sv/dvrt_checker.sv
tb/sv/tb.sv
